[hw/rtl/ossr_pkg.sv]
`timescale 1ns / 1ps

package ossr_pkg;

  // Field widths fixed by the interface
  localparam int unsigned NSLOT_W = 11;
  localparam int unsigned RANK_W  = 10;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Default tree size and register defaults
  localparam int unsigned MAX_SLOTS_DEF = 1024;
  localparam logic [NSLOT_W-1:0] N_SLOTS_RST = 11'd1024;

  // Register index (byte address 4*i, index sits in paddr[2])
  localparam logic REG_N_SLOTS = 1'b0;

  // Request codes
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_TAKE    = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;     // latch request, precompute error and wanted rank
    logic sweep_step;  // write one restart node value, advance index
    logic desc_read;   // read the node at pos + step
    logic desc_cmp;    // descend decision on the read node count
    logic rem_start;   // start the removal walk at pos + 1
    logic rem_read;    // read the node at the walk index
    logic rem_write;   // write back count - 1, advance by low bit
    logic load_result; // load the output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic req_take;   // captured request is a take
    logic rank_err;   // captured take rank is out of range
    logic sweep_last; // sweep index is at the last node
    logic step_last;  // descent step is one
    logic rem_last;   // next removal index is beyond the tree
    logic out_busy;   // output register holds a word not yet taken
  } sts_t;

endpackage

[hw/rtl/ossr_ram.sv]
`timescale 1ns / 1ps

module ossr_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ossr_ctrl.sv]
`timescale 1ns / 1ps

module ossr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ossr_pkg::sts_t sts_i,
  output ossr_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_D_RD  = 3'd2;
  localparam logic [2:0] ST_D_CMP = 3'd3;
  localparam logic [2:0] ST_R_BEG = 3'd4;
  localparam logic [2:0] ST_R_RD  = 3'd5;
  localparam logic [2:0] ST_R_WR  = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_D_RD;
        end
      end
      ST_D_RD: begin
        // entered after capture and after each descent compare: route by the latched request
        if (!sts_i.req_take) begin
          state_d = ST_SWEEP;
        end else if (sts_i.rank_err) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.desc_read = 1'b1;
          state_d         = ST_D_CMP;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_FIN;
        end
      end
      ST_D_CMP: begin
        cmd_o.desc_cmp = 1'b1;
        if (sts_i.step_last) begin
          state_d = ST_R_BEG;
        end else begin
          state_d = ST_D_RD;
        end
      end
      ST_R_BEG: begin
        cmd_o.rem_start = 1'b1;
        state_d         = ST_R_RD;
      end
      ST_R_RD: begin
        cmd_o.rem_read = 1'b1;
        state_d        = ST_R_WR;
      end
      ST_R_WR: begin
        cmd_o.rem_write = 1'b1;
        if (sts_i.rem_last) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_R_RD;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/ossr_dp.sv]
`timescale 1ns / 1ps

module ossr_dp #(
  parameter int unsigned MAX_SLOTS = ossr_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ossr_pkg::NSLOT_W-1:0]  n_slots_i,
  input  logic                          req_type_i,
  input  logic [ossr_pkg::RANK_W-1:0]   rank_above_i,
  input  ossr_pkg::cmd_t                cmd_i,
  output ossr_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ossr_pkg::NSLOT_W-1:0]  slot_o,
  output logic [ossr_pkg::NSLOT_W-1:0]  remaining_o,
  output logic                          status_o
);

  // Count / index width, address width, compare widths
  localparam int unsigned CW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned AW  = $clog2(MAX_SLOTS);
  localparam int unsigned NW  = (CW > ossr_pkg::NSLOT_W) ? CW : ossr_pkg::NSLOT_W;
  localparam int unsigned RW  = (CW > ossr_pkg::RANK_W) ? CW : ossr_pkg::RANK_W;
  localparam logic [CW-1:0] MAX_C   = CW'(MAX_SLOTS);
  localparam logic [CW:0]   MAX_X   = (CW + 1)'(MAX_SLOTS);
  localparam logic [NW-1:0] MAX_N   = NW'(MAX_SLOTS);
  localparam logic [CW-1:0] TOP_STEP = CW'(1) << (CW - 1);

  logic          req_q;
  logic          err_q;
  logic [CW-1:0] active_q;
  logic [CW-1:0] want_q;
  logic [CW-1:0] pos_q;
  logic [CW-1:0] step_q;
  logic [CW-1:0] idx_q;

  logic                         out_valid_q;
  logic [ossr_pkg::NSLOT_W-1:0] slot_q;
  logic [ossr_pkg::NSLOT_W-1:0] remaining_q;
  logic                         status_q;

  logic [CW-1:0] ram_rdata;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata;

  // Restart count, saturated to the tree size
  logic [NW-1:0] n_ext;
  logic [CW-1:0] n_sat;
  assign n_ext = NW'(n_slots_i);
  assign n_sat = (n_ext > MAX_N) ? MAX_C : CW'(n_ext);

  // Rank check at capture
  logic rank_err;
  assign rank_err = (req_type_i == ossr_pkg::REQ_TAKE) &&
                    (RW'(rank_above_i) >= RW'(active_q));

  // Walk index helpers: low bit, restart node value, next removal index
  logic [CW-1:0] lowbit, node_lo, node_hi, fill_val, idx_m1;
  logic [CW:0]   idx_nx;
  assign lowbit   = idx_q & (~idx_q + CW'(1));
  assign node_lo  = idx_q - lowbit;
  assign node_hi  = (idx_q < n_sat) ? idx_q : n_sat;
  assign fill_val = (node_hi > node_lo) ? (node_hi - node_lo) : '0;
  assign idx_m1   = idx_q - CW'(1);
  assign idx_nx   = (CW + 1)'(idx_q) + (CW + 1)'(lowbit);

  // Descent helpers
  logic [CW:0] nxt, nxt_m1;
  logic        nxt_ok, go_right;
  assign nxt      = (CW + 1)'(pos_q) + (CW + 1)'(step_q);
  assign nxt_m1   = nxt - (CW + 1)'(1);
  assign nxt_ok   = (nxt <= MAX_X);
  assign go_right = nxt_ok && (ram_rdata < want_q);

  // Tree memory port steering
  assign ram_we    = cmd_i.sweep_step || cmd_i.rem_write;
  assign ram_waddr = idx_m1[AW-1:0];
  assign ram_wdata = cmd_i.sweep_step ? fill_val : (ram_rdata - CW'(1));
  assign ram_re    = cmd_i.desc_read || cmd_i.rem_read;
  assign ram_raddr = cmd_i.desc_read ? nxt_m1[AW-1:0] : idx_m1[AW-1:0];

  ossr_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_SLOTS)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Active count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.capture && (req_type_i == ossr_pkg::REQ_RESTART)) begin
      active_q <= n_sat;
    end else if (cmd_i.rem_start) begin
      active_q <= active_q - CW'(1);
    end
  end

  // Request and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      err_q  <= rank_err;
      want_q <= CW'(RW'(active_q) - RW'(rank_above_i));
      pos_q  <= '0;
      step_q <= TOP_STEP;
      idx_q  <= CW'(1);
    end else begin
      if (cmd_i.sweep_step) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.desc_cmp) begin
        step_q <= step_q >> 1;
        if (go_right) begin
          pos_q  <= CW'(nxt);
          want_q <= want_q - ram_rdata;
        end
      end
      if (cmd_i.rem_start) begin
        idx_q <= pos_q + CW'(1);
      end
      if (cmd_i.rem_write) begin
        idx_q <= CW'(idx_nx);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      slot_q      <= (req_q && !err_q) ? ossr_pkg::NSLOT_W'(pos_q + CW'(1)) : '0;
      remaining_q <= ossr_pkg::NSLOT_W'(active_q);
      status_q    <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign remaining_o = remaining_q;
  assign status_o    = status_q;

  // Status to the controller
  assign sts_o.req_take   = req_q;
  assign sts_o.rank_err   = err_q;
  assign sts_o.sweep_last = (idx_q == MAX_C);
  assign sts_o.step_last  = (step_q == CW'(1));
  assign sts_o.rem_last   = (idx_nx > MAX_X);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

[hw/rtl/order_statistic_select_remove.sv]
`timescale 1ns / 1ps

// Order-statistic slot picker over a Fenwick count tree held in one RAM of
// MAX_SLOTS entries. A restart word (req_type 0) rebuilds the tree with slots
// 1..n_slots active (n_slots saturates at MAX_SLOTS) by sweeping every node.
// A take word (req_type 1) finds the active slot with rank_above active slots
// above it, removes it and returns its number. The rank is checked as the word
// is taken. The search makes one RAM read and one compare per descent level
// over floor(log2(MAX_SLOTS)) + 1 levels. The update path starts the walk and
// then reads and writes back each node, at most floor(log2(MAX_SLOTS)) + 1
// nodes, before the result is loaded. The tree RAM has a single
// registered-read port. A take whose rank is not below the active count
// returns status 1 and removes nothing. Every word gives exactly one result
// word; the result sits in an output register, so the next word is taken
// while it waits, but that word holds in its last cycle until the waiting
// result is taken. The tree contents are undefined after reset; no slot is
// active until the first restart. Register n_slots lives at byte address 0
// of the APB port.
module order_statistic_select_remove #(
  parameter int unsigned MAX_SLOTS = ossr_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [ossr_pkg::RANK_W-1:0]   rank_above_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ossr_pkg::NSLOT_W-1:0]  slot_o,
  output logic [ossr_pkg::NSLOT_W-1:0]  remaining_o,
  output logic                          status_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ossr_pkg::APB_AW-1:0]   paddr,
  input  logic [ossr_pkg::APB_DW-1:0]   pwdata,
  output logic [ossr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [ossr_pkg::NSLOT_W-1:0] n_slots_q;
  logic                         reg_hit;
  ossr_pkg::cmd_t               cmd;
  ossr_pkg::sts_t               sts;

  // Register decode
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == ossr_pkg::REG_N_SLOTS);
  assign prdata  = reg_hit ? ossr_pkg::APB_DW'(n_slots_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_slots_q <= ossr_pkg::N_SLOTS_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      n_slots_q <= pwdata[ossr_pkg::NSLOT_W-1:0];
    end
  end

  ossr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ossr_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_slots_i    (n_slots_q),
    .req_type_i   (req_type_i),
    .rank_above_i (rank_above_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slot_o       (slot_o),
    .remaining_o  (remaining_o),
    .status_o     (status_o)
  );

endmodule
